[hdl/mrpt_pkg.sv]
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared widths, constants and sequencer states for the prime test unit.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int NUM_WIDTH  = 63;
    localparam int CNT_WIDTH  = $clog2(NUM_WIDTH + 1);
    localparam int NUM_SMALL  = 12;
    localparam int NUM_WIT    = 7;
    localparam int SIDX_WIDTH = $clog2(NUM_SMALL);
    localparam int WIDX_WIDTH = $clog2(NUM_WIT);
    localparam int TDATA_IN_W = ((NUM_WIDTH + 7) / 8) * 8;

    typedef logic [NUM_WIDTH-1:0] t_num;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SMALL_INIT,   // start remainder by small prime
        ST_SMALL_STEP,   // one bit of shift-subtract remainder
        ST_SMALL_CHECK,
        ST_SPLIT,        // strip trailing zeros of n-1
        ST_WIT_INIT,
        ST_WRED_STEP,    // witness mod n, bit-serial
        ST_WRED_DONE,
        ST_POW_BIT,      // choose next exponent bit
        ST_MUL_STEP,     // shared modular multiplier, one bit a cycle
        ST_POW_CHECK,
        ST_SQ_NEXT,
        ST_WIT_PASS,     // advance to the next witness or finish
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_POW_ACC,
        MUL_POW_SQ,
        MUL_SQ_LOOP
    } t_mul_kind;

    function automatic logic [5:0] small_prime(input logic [SIDX_WIDTH-1:0] k);
        case (k)
            4'd0:    small_prime = 6'd2;
            4'd1:    small_prime = 6'd3;
            4'd2:    small_prime = 6'd5;
            4'd3:    small_prime = 6'd7;
            4'd4:    small_prime = 6'd11;
            4'd5:    small_prime = 6'd13;
            4'd6:    small_prime = 6'd17;
            4'd7:    small_prime = 6'd19;
            4'd8:    small_prime = 6'd23;
            4'd9:    small_prime = 6'd29;
            4'd10:   small_prime = 6'd31;
            4'd11:   small_prime = 6'd37;
            default: small_prime = 6'd37;
        endcase
    endfunction

    function automatic logic [30:0] witness(input logic [WIDX_WIDTH-1:0] k);
        case (k)
            3'd0:    witness = 31'd2;
            3'd1:    witness = 31'd325;
            3'd2:    witness = 31'd9375;
            3'd3:    witness = 31'd28178;
            3'd4:    witness = 31'd450775;
            3'd5:    witness = 31'd9780504;
            3'd6:    witness = 31'd1795265022;
            default: witness = 31'd2;
        endcase
    endfunction

endpackage

[hdl/miller_rabin_prime_test_unit.sv]
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_unit
// Deterministic Miller-Rabin primality test of a 63-bit integer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one candidate per word (tdata[62:0]).
//   Master channel m_axis_* returns one word per candidate, tdata[0] set
//   when the candidate is prime.
//   One item is worked at a time; s_axis_tready is high only when the unit
//   is idle and its result register is free to be refilled.
//   Small cases are settled by trial division, one small prime at a time.
//   Full cases run up to seven witnesses; each modular product is formed
//   on the shared bit-serial multiply-reduce unit, one product at a time.
//   A 63-bit prime needs about 650 products, at most about 870 products
//   per item.
//   Witness reduction and small-prime remainders use the same
//   one-bit-per-cycle shift-subtract step.
//   Reset empties the result register and returns the sequencer to idle.
//   A stalled receiver holds the result; the next candidate is taken once
//   the result has been read.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mrpt_pkg::TDATA_IN_W-1:0] s_axis_tdata,  // [62:0] candidate
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata   // [0] is_prime
);
    import mrpt_pkg::*;

    t_state    r_state, n_state;
    t_num      r_n, r_d, r_x, r_acc, r_b, r_e, r_y, r_m;
    t_num      n_nv, n_d, n_x, n_acc, n_b, n_e, n_y, n_m;
    logic [CNT_WIDTH-1:0]  r_s, n_s, r_cnt, n_cnt, r_i, n_i;
    logic [SIDX_WIDTH-1:0] r_k, n_k;
    logic [WIDX_WIDTH-1:0] r_w, n_w;
    t_mul_kind r_kind, n_kind;
    logic      r_ov, n_ov, r_res, n_res;

    logic [NUM_WIDTH:0] sh, sh2, add1;
    t_num red1, red2;
    t_num nm1;
    logic in_go;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ov;
    assign in_go         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_res};
    assign nm1           = r_n - t_num'(1);

    // shared unit: acc = 2*acc (+ x) mod m, input bit from top of r_y
    always_comb begin
        sh   = {r_acc, 1'b0};
        red1 = (sh >= {1'b0, r_m}) ? t_num'(sh - {1'b0, r_m}) : sh[NUM_WIDTH-1:0];
        add1 = {1'b0, red1} + {1'b0, r_x};
        sh2  = add1;
        red2 = (sh2 >= {1'b0, r_m}) ? t_num'(sh2 - {1'b0, r_m}) : sh2[NUM_WIDTH-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_nv = r_n; n_d = r_d; n_x = r_x; n_acc = r_acc; n_b = r_b; n_e = r_e;
        n_y = r_y; n_m = r_m; n_s = r_s; n_cnt = r_cnt; n_i = r_i; n_k = r_k;
        n_w = r_w; n_kind = r_kind; n_ov = r_ov; n_res = r_res;
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_go) begin
                    n_nv = s_axis_tdata[NUM_WIDTH-1:0];
                    n_k  = '0;
                    if (s_axis_tdata[NUM_WIDTH-1:0] < t_num'(2)) begin
                        n_res = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SMALL_INIT;
                    end
                end
            end
            ST_SMALL_INIT: begin
                // remainder of n by small prime: feed n bits, add 1 per set bit
                n_acc = '0; n_x = t_num'(1); n_y = r_n;
                n_m = t_num'(small_prime(r_k));
                n_cnt = CNT_WIDTH'(NUM_WIDTH);
                n_state = ST_SMALL_STEP;
            end
            ST_SMALL_STEP: begin
                n_acc = r_y[NUM_WIDTH-1] ? red2 : red1;
                n_y = {r_y[NUM_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_WIDTH'(1)) n_state = ST_SMALL_CHECK;
            end
            ST_SMALL_CHECK: begin
                if (r_acc == '0) begin
                    n_res = (r_n == r_m);
                    n_state = ST_DONE;
                end else if (r_k == SIDX_WIDTH'(NUM_SMALL - 1)) begin
                    n_d = nm1; n_s = '0;
                    n_state = ST_SPLIT;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = ST_SMALL_INIT;
                end
            end
            ST_SPLIT: begin
                if (r_d[0]) begin
                    n_w = '0;
                    n_state = ST_WIT_INIT;
                end else begin
                    n_d = r_d >> 1;
                    n_s = r_s + 1'b1;
                end
            end
            ST_WIT_INIT: begin
                n_acc = '0; n_x = t_num'(1); n_m = r_n;
                n_y = t_num'(witness(r_w)) << (NUM_WIDTH - 31);
                n_cnt = CNT_WIDTH'(31);
                n_state = ST_WRED_STEP;
            end
            ST_WRED_STEP: begin
                n_acc = r_y[NUM_WIDTH-1] ? red2 : red1;
                n_y = {r_y[NUM_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_WIDTH'(1)) n_state = ST_WRED_DONE;
            end
            ST_WRED_DONE: begin
                if (r_acc == '0) begin
                    n_state = ST_WIT_PASS;
                end else begin
                    n_b = r_acc; n_e = r_d; n_x = t_num'(1);
                    n_state = ST_POW_BIT;
                end
            end
            ST_POW_BIT: begin
                // r_x holds power accumulator here; r_b base
                if (r_e == '0) begin
                    n_state = ST_POW_CHECK;
                end else begin
                    n_acc = '0; n_cnt = CNT_WIDTH'(NUM_WIDTH);
                    n_y = r_b;
                    n_m = r_n;
                    if (r_e[0]) begin
                        n_kind = MUL_POW_ACC;
                        n_b = r_x; n_x = r_b;   // acc*b: y=acc, x=b -> swap roles
                        n_y = r_x;
                    end else begin
                        n_kind = MUL_POW_SQ;
                        n_b = r_x; n_x = r_b;
                    end
                    n_state = ST_MUL_STEP;
                end
            end
            ST_MUL_STEP: begin
                n_acc = r_y[NUM_WIDTH-1] ? red2 : red1;
                n_y = {r_y[NUM_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_WIDTH'(1)) begin
                    case (r_kind)
                        MUL_POW_ACC: begin
                            // keep new power acc in r_b, then square base in r_x
                            n_b = n_acc;
                            n_y = r_x;
                            n_acc = '0; n_cnt = CNT_WIDTH'(NUM_WIDTH);
                            n_kind = MUL_POW_SQ;
                        end
                        MUL_POW_SQ: begin
                            // r_b holds power acc, result is new base
                            n_x = r_b;
                            n_b = n_acc;
                            n_e = r_e >> 1;
                            n_state = ST_POW_BIT;
                        end
                        MUL_SQ_LOOP: begin
                            n_x = n_acc;
                            n_state = ST_SQ_NEXT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_POW_CHECK: begin
                if (r_x == t_num'(1) || r_x == nm1) begin
                    n_state = ST_WIT_PASS;
                end else if (r_s <= CNT_WIDTH'(1)) begin
                    n_res = 1'b0; n_state = ST_DONE;
                end else begin
                    // first squaring after the power
                    n_i = CNT_WIDTH'(1);
                    n_kind = MUL_SQ_LOOP; n_acc = '0; n_y = r_x; n_m = r_n;
                    n_cnt = CNT_WIDTH'(NUM_WIDTH); n_state = ST_MUL_STEP;
                end
            end
            ST_SQ_NEXT: begin
                // r_i squarings done so far
                if (r_x == nm1) begin
                    n_state = ST_WIT_PASS;
                end else if (r_i + 1'b1 >= r_s) begin
                    n_res = 1'b0; n_state = ST_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_kind = MUL_SQ_LOOP; n_acc = '0; n_y = r_x; n_m = r_n;
                    n_cnt = CNT_WIDTH'(NUM_WIDTH); n_state = ST_MUL_STEP;
                end
            end
            ST_WIT_PASS: begin
                if (r_w == WIDX_WIDTH'(NUM_WIT - 1)) begin
                    n_res = 1'b1; n_state = ST_DONE;
                end else begin
                    n_w = r_w + 1'b1; n_state = ST_WIT_INIT;
                end
            end
            ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_kind  <= MUL_POW_ACC;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_kind  <= n_kind;
        end
        r_n <= n_nv; r_d <= n_d; r_x <= n_x; r_acc <= n_acc; r_b <= n_b;
        r_e <= n_e; r_y <= n_y; r_m <= n_m; r_s <= n_s; r_cnt <= n_cnt;
        r_i <= n_i; r_k <= n_k; r_w <= n_w; r_res <= n_res;
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != ST_IDLE))
        else $error("accepted item not started");

endmodule
